// File: sv/plsu_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and the escape letter table of the literal string decoder.
package plsu_pkg;

   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_ZERO      = 8'h30;
   localparam logic [7:0] CHAR_SEVEN     = 8'h37;
   localparam logic [7:0] CHAR_CR        = 8'h0D;
   localparam logic [7:0] CHAR_LF        = 8'h0A;
   localparam logic [7:0] CHAR_PERCENT   = 8'h25;
   localparam logic [7:0] CHAR_LPAREN    = 8'h28;
   localparam logic [7:0] CHAR_RPAREN    = 8'h29;
   localparam logic [1:0] OCTAL_MAX      = 2'd3;

   localparam int         CSR_ADDR_W     = 3;
   localparam logic [CSR_ADDR_W-1:0] REG_STRIP_WRAPPING = 3'd0;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_byte;
      logic       unknown_escape;
      logic       out_last;
   } result_type;

   typedef struct packed {
      logic       known;
      logic [7:0] code;
   } escape_type;

   function automatic escape_type escape_letter(input logic [7:0] ch);
      escape_type res;
      res.known = 1'b1;
      res.code  = ch;
      case (ch)
         8'h74: res.code = 8'h09;
         8'h72: res.code = 8'h0D;
         8'h6E: res.code = 8'h0A;
         8'h62: res.code = 8'h08;
         8'h66: res.code = 8'h0C;
         8'h61: res.code = 8'h07;
         8'h76: res.code = 8'h0B;
         8'h65: res.code = 8'h1B;
         CHAR_PERCENT, CHAR_BACKSLASH, CHAR_LPAREN, CHAR_RPAREN: res.code = ch;
         default: res.known = 1'b0;
      endcase
      return res;
   endfunction

endpackage

// File: sv/pdf_literal_string_unescape.sv
`timescale 1ns / 1ps
// Top level of the literal string escape decoder with its result queue and register port.
//
// The req channel carries the escaped body of a literal string, one byte per
// transfer, with req_tlast on its final byte. The rsp channel returns decoded
// bytes; rsp_tuser[0] flags a carried byte and rsp_tuser[1] an unknown escape.
// rsp_tlast marks the final result of a string; a string end that yields no
// byte still gives one result with rsp_tuser[0] low.
// Each accepted byte is decoded in the cycle of its transfer and yields zero,
// one or two results, which enter a four-entry result queue; results reach
// rsp only through this registered queue. One byte per cycle is taken
// while the queue holds at most two results, so a byte stream with one result
// per byte runs at one byte per cycle while the receiver takes each result;
// bytes that yield two results need two rsp transfers each.
// When the receiver stalls, the queue fills and req_tready drops until it
// holds at most two results again. The csr port holds strip_wrapping at
// address 0; it drops the first and last byte of each string. Reset empties
// the queue, clears the decoder state and clears strip_wrapping.
module pdf_literal_string_unescape
   import plsu_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // in_byte
   input  logic                  req_tlast,   // in_last
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,   // out_byte
   output logic [1:0]            rsp_tuser,   // has_byte, unknown_escape
   output logic                  rsp_tlast,   // out_last
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   logic       strip_ff, strip_in;
   logic       esc_ff, esc_in;
   logic [1:0] cnt_ff, cnt_in;
   logic [7:0] val_ff, val_in;
   logic       start_ff, start_in;

   result_type mem_ff [4];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;

   logic       accept, pop, csr_write;
   logic [1:0] push_n;
   result_type item0, item1;

   assign accept     = req_tvalid && req_tready;
   assign pop        = rsp_tvalid && rsp_tready;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == REG_STRIP_WRAPPING) ? {31'd0, strip_ff} : 32'd0;
   assign strip_in   = (csr_write && csr_paddr == REG_STRIP_WRAPPING) ? csr_pwdata[0] : strip_ff;

   always_comb begin
      logic       drop, is_oct, absorbed;
      logic       e_flush, e_main, e_end;
      logic [7:0] flush_val, main_byte, end_val;
      logic       main_unk;
      escape_type esc_map;
      result_type r_flush, r_main, r_end, empty;
      logic [1:0] n;

      esc_in    = esc_ff;
      cnt_in    = cnt_ff;
      val_in    = val_ff;
      start_in  = start_ff;
      e_flush   = 1'b0;
      e_main    = 1'b0;
      e_end     = 1'b0;
      absorbed  = 1'b0;
      flush_val = val_ff;
      main_byte = req_tdata;
      main_unk  = 1'b0;
      end_val   = 8'd0;
      is_oct    = (req_tdata >= CHAR_ZERO) && (req_tdata <= CHAR_SEVEN);
      esc_map   = escape_letter(req_tdata);
      drop      = strip_ff && (start_ff || req_tlast);

      if (accept) begin
         start_in = 1'b0;
         if (!drop) begin
            if (cnt_ff != 2'd0) begin
               if (cnt_ff < OCTAL_MAX && is_oct) begin
                  val_in   = {val_ff[4:0], req_tdata[2:0]};
                  cnt_in   = cnt_ff + 2'd1;
                  absorbed = 1'b1;
               end else begin
                  e_flush = 1'b1;
                  cnt_in  = 2'd0;
                  val_in  = 8'd0;
               end
            end
            if (!absorbed) begin
               if (esc_ff) begin
                  esc_in = 1'b0;
                  if (is_oct) begin
                     cnt_in = 2'd1;
                     val_in = {5'd0, req_tdata[2:0]};
                  end else if (req_tdata != CHAR_CR && req_tdata != CHAR_LF) begin
                     e_main    = 1'b1;
                     main_byte = esc_map.code;
                     main_unk  = !esc_map.known;
                  end
               end else if (req_tdata == CHAR_BACKSLASH) begin
                  esc_in = 1'b1;
               end else begin
                  e_main = 1'b1;
               end
            end
         end
         if (req_tlast) begin
            e_end    = (cnt_in != 2'd0);
            end_val  = val_in;
            esc_in   = 1'b0;
            cnt_in   = 2'd0;
            val_in   = 8'd0;
            start_in = 1'b1;
         end
      end

      r_flush = '{out_byte: flush_val, has_byte: 1'b1, unknown_escape: 1'b0, out_last: 1'b0};
      r_main  = '{out_byte: main_byte, has_byte: 1'b1, unknown_escape: main_unk,
                  out_last: 1'b0};
      r_end   = '{out_byte: end_val, has_byte: 1'b1, unknown_escape: 1'b0, out_last: 1'b0};
      empty   = '{out_byte: 8'd0, has_byte: 1'b0, unknown_escape: 1'b0, out_last: 1'b0};

      item0 = e_flush ? r_flush : (e_main ? r_main : (e_end ? r_end : empty));
      item1 = (e_flush && e_main) ? r_main : r_end;
      n = {1'b0, e_flush} + {1'b0, e_main} + {1'b0, e_end};
      if (accept && req_tlast && n == 2'd0) begin
         n = 2'd1;
      end
      if (accept && req_tlast) begin
         if (n == 2'd2) begin
            item1.out_last = 1'b1;
         end else begin
            item0.out_last = 1'b1;
         end
      end
      push_n = accept ? n : 2'd0;
   end

   assign wr_ptr_in  = wr_ptr_ff + push_n;
   assign rd_ptr_in  = rd_ptr_ff + {1'b0, pop};
   assign count_in   = count_ff + {1'b0, push_n} - {2'd0, pop};
   assign req_tready = (count_ff <= 3'd2);
   assign rsp_tvalid = (count_ff != 3'd0);
   assign rsp_tdata  = mem_ff[rd_ptr_ff].out_byte;
   assign rsp_tuser  = {mem_ff[rd_ptr_ff].unknown_escape, mem_ff[rd_ptr_ff].has_byte};
   assign rsp_tlast  = mem_ff[rd_ptr_ff].out_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         strip_ff  <= 1'b0;
         esc_ff    <= 1'b0;
         cnt_ff    <= 2'd0;
         val_ff    <= 8'd0;
         start_ff  <= 1'b1;
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 3'd0;
      end else begin
         strip_ff  <= strip_in;
         esc_ff    <= esc_in;
         cnt_ff    <= cnt_in;
         val_ff    <= val_in;
         start_ff  <= start_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         mem_ff[wr_ptr_ff] <= item0;
      end
      if (push_n == 2'd2) begin
         mem_ff[wr_ptr_ff + 2'd1] <= item1;
      end
   end

endmodule

// File: sv/plsu_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the literal string decoder and its bind statement.
module plsu_checker
   import plsu_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic [1:0] rsp_tuser,
   input logic       rsp_tlast
);

   // A result without a byte only ever marks the end of a string.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tlast && rsp_tdata == 8'd0 && !rsp_tuser[1])
      else $error("empty result that is not a string end");

   // Backpressure on req only comes from results waiting on rsp.
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("req stalled with no pending result");

   // Reset empties the result queue.
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered right after reset");

   // A stalled result transfer holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

endmodule

bind pdf_literal_string_unescape plsu_checker u_plsu_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// File: dv/pdf_literal_string_unescape_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the literal string decoder: directed and random strings.
module pdf_literal_string_unescape_tb;
   import plsu_pkg::*;

   localparam logic [7:0] CH_T     = 8'h74;
   localparam logic [7:0] CH_R     = 8'h72;
   localparam logic [7:0] CH_N     = 8'h6E;
   localparam logic [7:0] CH_B     = 8'h62;
   localparam logic [7:0] CH_F     = 8'h66;
   localparam logic [7:0] CH_A     = 8'h61;
   localparam logic [7:0] CH_V     = 8'h76;
   localparam logic [7:0] CH_E     = 8'h65;
   localparam logic [7:0] CODE_TAB = 8'h09;
   localparam logic [7:0] CODE_BS  = 8'h08;
   localparam logic [7:0] CODE_FF  = 8'h0C;
   localparam logic [7:0] CODE_BEL = 8'h07;
   localparam logic [7:0] CODE_VT  = 8'h0B;
   localparam logic [7:0] CODE_ESC = 8'h1B;
   localparam int         SETTLE_CYCLES = 8;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [7:0]            req_tdata;   // in_byte
   logic                  req_tlast;   // in_last
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [7:0]            rsp_tdata;   // out_byte
   logic [1:0]            rsp_tuser;   // has_byte, unknown_escape
   logic                  rsp_tlast;   // out_last
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0]           csr_pwdata;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   result_type decoded_due[$];
   logic [7:0] str_q[$];
   int         mismatch_count = 0;
   bit         idle_enable = 1'b0;
   int         rsp_stall_left = 0;

   logic       strip_wrap = 1'b0;
   logic       esc_open   = 1'b0;
   logic [1:0] oct_digits = 2'd0;
   logic [7:0] oct_acc    = 8'd0;
   logic       str_start  = 1'b1;

   pdf_literal_string_unescape u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   function automatic void push_decoded(input logic [7:0] b, input logic unk);
      result_type r;
      r.out_byte       = b;
      r.has_byte       = 1'b1;
      r.unknown_escape = unk;
      r.out_last       = 1'b0;
      decoded_due.push_back(r);
   endfunction

   function automatic void decode_one(input logic [7:0] b);
      logic is_oct;
      is_oct = (b >= CHAR_ZERO) && (b <= CHAR_SEVEN);
      if (oct_digits != 2'd0) begin
         if (oct_digits < OCTAL_MAX && is_oct) begin
            oct_acc    = {oct_acc[4:0], b[2:0]};
            oct_digits = oct_digits + 2'd1;
            return;
         end
         push_decoded(oct_acc, 1'b0);
         oct_digits = 2'd0;
         oct_acc    = 8'd0;
      end
      if (esc_open) begin
         esc_open = 1'b0;
         if (is_oct) begin
            oct_digits = 2'd1;
            oct_acc    = {5'd0, b[2:0]};
            return;
         end
         case (b)
            CHAR_CR, CHAR_LF: ;
            CH_T: push_decoded(CODE_TAB, 1'b0);
            CH_R: push_decoded(CHAR_CR, 1'b0);
            CH_N: push_decoded(CHAR_LF, 1'b0);
            CH_B: push_decoded(CODE_BS, 1'b0);
            CH_F: push_decoded(CODE_FF, 1'b0);
            CH_A: push_decoded(CODE_BEL, 1'b0);
            CH_V: push_decoded(CODE_VT, 1'b0);
            CH_E: push_decoded(CODE_ESC, 1'b0);
            CHAR_PERCENT, CHAR_BACKSLASH, CHAR_LPAREN, CHAR_RPAREN: push_decoded(b, 1'b0);
            default: push_decoded(b, 1'b1);
         endcase
         return;
      end
      if (b == CHAR_BACKSLASH) esc_open = 1'b1;
      else push_decoded(b, 1'b0);
   endfunction

   function automatic void unescape_transfer(input logic [7:0] b, input logic last);
      int         due_count;
      result_type r;
      due_count = decoded_due.size();
      if (!(strip_wrap && (str_start || last))) decode_one(b);
      str_start = 1'b0;
      if (last) begin
         if (oct_digits != 2'd0) push_decoded(oct_acc, 1'b0);
         if (decoded_due.size() == due_count) begin
            r = '0;
            decoded_due.push_back(r);
         end
         r = decoded_due.pop_back();
         r.out_last = 1'b1;
         decoded_due.push_back(r);
         esc_open   = 1'b0;
         oct_digits = 2'd0;
         oct_acc    = 8'd0;
         str_start  = 1'b1;
      end
   endfunction

   function automatic void report_mismatch(input result_type want, input result_type got,
                                           input bit none_due);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         if (none_due)
            $display("Unexpected result: byte %02h has %0b unk %0b last %0b", got.out_byte,
                     got.has_byte, got.unknown_escape, got.out_last);
         else
            $display("Result mismatch: expected %02h/%0b/%0b/%0b, got %02h/%0b/%0b/%0b",
                     want.out_byte, want.has_byte, want.unknown_escape, want.out_last,
                     got.out_byte, got.has_byte, got.unknown_escape, got.out_last);
      end
   endfunction

   always @(posedge clock) begin
      result_type want;
      result_type got;
      if (!reset) begin
         if (req_tvalid && req_tready) unescape_transfer(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            got.out_byte       = rsp_tdata;
            got.has_byte       = rsp_tuser[0];
            got.unknown_escape = rsp_tuser[1];
            got.out_last       = rsp_tlast;
            if (decoded_due.size() == 0) begin
               want = '0;
               report_mismatch(want, got, 1'b1);
            end else begin
               want = decoded_due.pop_front();
               if (got.out_byte !== want.out_byte || got.has_byte !== want.has_byte ||
                   got.unknown_escape !== want.unknown_escape || got.out_last !== want.out_last)
                  report_mismatch(want, got, 1'b0);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (rsp_stall_left != 0) begin
         rsp_tready     <= 1'b0;
         rsp_stall_left <= rsp_stall_left - 1;
      end else if (idle_enable && $urandom_range(0, 5) == 0) begin
         rsp_tready     <= 1'b0;
         rsp_stall_left <= $urandom_range(0, 2);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      if (idle_enable && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 3);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (decoded_due.size() != 0);
   endtask

   task automatic send_string(input bit pause_before_last);
      for (int i = 0; i < str_q.size(); i++) begin
         if (pause_before_last && i == str_q.size() - 1) wait_drained();
         send_byte(str_q[i], i == str_q.size() - 1);
      end
   endtask

   task automatic apply_strip_wrapping(input logic value);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= REG_STRIP_WRAPPING;
      csr_pwdata  <= {31'($urandom()), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      strip_wrap = value;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== {31'd0, strip_wrap}) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("Register readback mismatch: expected %08h, got %08h",
                     {31'd0, strip_wrap}, csr_prdata);
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [7:0] named_escape(input int idx);
      case (idx)
         0: return CH_T;
         1: return CH_R;
         2: return CH_N;
         3: return CH_B;
         4: return CH_F;
         5: return CH_A;
         6: return CH_V;
         7: return CH_E;
         8: return CHAR_PERCENT;
         9: return CHAR_BACKSLASH;
         10: return CHAR_LPAREN;
         default: return CHAR_RPAREN;
      endcase
   endfunction

   function automatic void add_token();
      int kind;
      int ndig;
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
         str_q.push_back(8'($urandom_range(0, 255)));
      end else if (kind < 62) begin
         str_q.push_back(CHAR_BACKSLASH);
         str_q.push_back(named_escape($urandom_range(0, 11)));
      end else if (kind < 82) begin
         str_q.push_back(CHAR_BACKSLASH);
         ndig = $urandom_range(1, 3);
         for (int i = 0; i < ndig; i++) str_q.push_back(8'(CHAR_ZERO + $urandom_range(0, 7)));
         if ($urandom_range(0, 3) == 0) str_q.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
      end else if (kind < 88) begin
         str_q.push_back(CHAR_BACKSLASH);
         str_q.push_back($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
      end else if (kind < 96) begin
         str_q.push_back(CHAR_BACKSLASH);
         str_q.push_back(8'($urandom_range(0, 255)));
      end else begin
         str_q.push_back(CHAR_BACKSLASH);
      end
   endfunction

   task automatic test_directed_escapes();
      str_q = '{8'h00, 8'hFF, CHAR_CR, CHAR_BACKSLASH, CH_N, CHAR_BACKSLASH, CHAR_CR,
                CHAR_BACKSLASH, CHAR_LF, CHAR_BACKSLASH, 8'h39, CHAR_BACKSLASH, 8'h37, 8'h37,
                8'h37, 8'h34, CHAR_BACKSLASH, 8'h31, 8'h32, 8'h78, CHAR_BACKSLASH, 8'h35};
      send_string(1'b0);
      str_q = '{8'h61, CHAR_BACKSLASH};
      send_string(1'b0);
   endtask

   task automatic test_directed_wrapping();
      str_q = '{CHAR_LPAREN, 8'h7A, CHAR_BACKSLASH, CHAR_RPAREN};
      send_string(1'b0);
      str_q = '{CHAR_LPAREN, CHAR_BACKSLASH, 8'h36, CHAR_RPAREN};
      send_string(1'b0);
      str_q = '{8'h55};
      send_string(1'b0);
   endtask

   task automatic test_random_strings(input int n_bytes, input bit wrap, input bit pressure);
      int sent;
      int ntok;
      int nstr;
      sent = 0;
      nstr = 0;
      while (sent < n_bytes) begin
         str_q.delete();
         if (wrap) str_q.push_back(CHAR_LPAREN);
         ntok = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 6);
         for (int i = 0; i < ntok; i++) add_token();
         if (wrap) str_q.push_back(CHAR_RPAREN);
         if (str_q.size() == 0) str_q.push_back(8'($urandom_range(0, 255)));
         send_string(pressure && (nstr % 40 == 7));
         sent += str_q.size();
         nstr++;
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= 8'd0;
      req_tlast  <= 1'b0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= 32'd0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      idle_enable = 1'b1;
      test_directed_escapes();
      apply_strip_wrapping(1'b1);
      test_directed_wrapping();
      apply_strip_wrapping(1'b0);
      test_random_strings(450, 1'b0, 1'b1);
      apply_strip_wrapping(1'b1);
      test_random_strings(450, 1'b1, 1'b1);
      apply_strip_wrapping(1'b0);
      test_random_strings(250, 1'b1, 1'b0);
      apply_strip_wrapping(1'b1);
      idle_enable = 1'b0;
      test_random_strings(350, 1'($urandom_range(0, 1)), 1'b0);
      wait_drained();
      repeat (16) @(posedge clock);
      if (mismatch_count == 0 && decoded_due.size() == 0) begin
         $display("pdf_literal_string_unescape: match");
      end else begin
         $display("pdf_literal_string_unescape: mismatch");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("pdf_literal_string_unescape: mismatch");
      $finish;
   end

endmodule

// File: files.f
sv/plsu_pkg.sv
sv/pdf_literal_string_unescape.sv
sv/plsu_checker.sv
dv/pdf_literal_string_unescape_tb.sv
